// File: hdl/i2cra_pkg.sv
`default_nettype none

package i2cra_pkg;

    // Write buffer depth and derived widths
    localparam int MAX_BYTES = 16;
    localparam int FILL_W    = $clog2(MAX_BYTES + 1);
    localparam int BUF_IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int BYI_W     = $clog2(MAX_BYTES + 3);

    // Timing register
    localparam int          TICK_W       = 16;
    localparam logic [15:0] PHASE_TICKS_RST = 16'd5;

    // Command codes
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_PUSH  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // Bus phases, one-hot
    typedef enum logic [17:0] {
        PH_IDLE    = 18'b000000000000000001,
        PH_ST_A    = 18'b000000000000000010,
        PH_ST_B    = 18'b000000000000000100,
        PH_WB_LO   = 18'b000000000000001000,
        PH_WB_HI   = 18'b000000000000010000,
        PH_WA_LO   = 18'b000000000000100000,
        PH_WA_HI   = 18'b000000000001000000,
        PH_RB_LO   = 18'b000000000010000000,
        PH_RB_HI1  = 18'b000000000100000000,
        PH_RB_HI2  = 18'b000000001000000000,
        PH_RA_LO   = 18'b000000010000000000,
        PH_RA_HI   = 18'b000000100000000000,
        PH_RA_LO2  = 18'b000001000000000000,
        PH_RA_END  = 18'b000010000000000000,
        PH_RS_PREP = 18'b000100000000000000,
        PH_SP_A    = 18'b001000000000000000,
        PH_SP_B    = 18'b010000000000000000,
        PH_SP_C    = 18'b100000000000000000
    } phase_t;

    // One result transaction
    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_drive;
        logic [7:0] rd_byte;
        logic       rd_valid;
        logic       rd_last;
        logic       busy_res;
        logic       done_res;
        logic       nack;
    } res_t;

endpackage

`default_nettype wire

// File: hdl/i2cra_if.sv
`default_nettype none

// Command channel: one bus tick per transaction
interface i2cra_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [6:0] dev_addr;
    logic [7:0] sub_addr;
    logic [4:0] byte_count;
    logic [7:0] wr_byte;
    logic       sda_in;

    modport source (
        output valid, op, dev_addr, sub_addr, byte_count, wr_byte, sda_in,
        input  ready
    );
    modport sink (
        input  valid, op, dev_addr, sub_addr, byte_count, wr_byte, sda_in,
        output ready
    );
endinterface

// Result channel: line levels and status for each tick
interface i2cra_res_if;
    logic       valid;
    logic       ready;
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic [7:0] rd_byte;
    logic       rd_valid;
    logic       rd_last;
    logic       busy_res;
    logic       done_res;
    logic       nack;

    modport source (
        output valid, scl, sda_out, sda_drive, rd_byte, rd_valid, rd_last,
               busy_res, done_res, nack,
        input  ready
    );
    modport sink (
        input  valid, scl, sda_out, sda_drive, rd_byte, rd_valid, rd_last,
               busy_res, done_res, nack,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/i2c_master_register_access_top.sv
// A result is registered on acceptance of its command and presented in the next cycle.
// Throughput: one tick per cycle, limited only by the result sink: a new command is
// taken only while the result register is empty or its result is taken in that cycle.
// Reset (rst_n, asynchronous, active low): bus idle with SCL and SDA high and driven,
// write buffer empty, phase_ticks back to 5; buffer contents are not cleared.
`default_nettype none

module i2c_master_register_access_top (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [15:0]             cfg_wdata,
    i2cra_cmd_if.sink                    cmd,
    i2cra_res_if.source                  res
);
    import i2cra_pkg::*;

    // Registers
    logic [TICK_W-1:0] phase_ticks_reg;
    phase_t            phase_reg, phase_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [3:0]        bit_idx_reg, bit_idx_next;
    logic [BYI_W-1:0]  byte_idx_reg, byte_idx_next;
    logic [7:0]        shift_reg, shift_next;
    logic [7:0]        write_buf_reg [MAX_BYTES];
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [6:0]        taddr_reg, taddr_next;
    logic [7:0]        treg_reg, treg_next;
    logic [FILL_W-1:0] tlen_reg, tlen_next;
    logic              ack_reg, ack_next;
    logic              sda_lvl_reg, sda_lvl_next;
    logic              rmode_reg, rmode_next;
    res_t              res_reg, res_next;
    logic              res_valid_reg;

    logic              accept;
    logic              buf_we;
    logic [BYI_W-1:0]  wb_k;
    logic              wb_in_range;
    logic [7:0]        wb_entry;
    logic [TICK_W-1:0] period;

    // Last byte of a read: byte_index - 2 >= transfer length (wraps like the unsigned form)
    function automatic logic is_last(input logic [BYI_W-1:0] byidx,
                                     input logic [FILL_W-1:0] tlen);
        logic [BYI_W:0] rel;
        rel = {1'b0, byidx} - (BYI_W + 1)'(2);
        return rel >= (BYI_W + 1)'(tlen);
    endfunction

    // Byte to send for a given byte index
    function automatic logic [7:0] tx_byte(input logic [BYI_W-1:0] byidx,
                                           input logic             rmode,
                                           input logic [6:0]       taddr,
                                           input logic [7:0]       treg,
                                           input logic [7:0]       entry);
        logic [7:0] b;
        if (byidx == BYI_W'(0))
        begin
            b = {taddr, 1'b0};
        end
        else if (byidx == BYI_W'(1))
        begin
            b = treg;
        end
        else if (rmode)
        begin
            b = {taddr, 1'b1};
        end
        else
        begin
            b = entry;
        end
        return b;
    endfunction

    // Handshake
    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = !res_valid_reg || res.ready;

    // Phase length, zero acts as one
    assign period = (phase_ticks_reg == '0) ? TICK_W'(1) : phase_ticks_reg;

    // Buffer entry for the next written data byte (new index minus two)
    assign wb_k        = byte_idx_reg - BYI_W'(1);
    assign wb_in_range = {1'b0, wb_k} < (BYI_W + 1)'(MAX_BYTES);
    assign wb_entry    = wb_in_range ? write_buf_reg[wb_k[BUF_IDX_W-1:0]] : 8'h00;

    // Next state and result for one tick
    always_comb
    begin
        logic [4:0] n;
        logic       last;
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        bit_idx_next  = bit_idx_reg;
        byte_idx_next = byte_idx_reg;
        shift_next    = shift_reg;
        fill_next     = fill_reg;
        taddr_next    = taddr_reg;
        treg_next     = treg_reg;
        tlen_next     = tlen_reg;
        ack_next      = ack_reg;
        rmode_next    = rmode_reg;
        sda_lvl_next  = sda_lvl_reg;
        buf_we        = 1'b0;
        res_next      = '0;
        res_next.scl       = 1'b1;
        res_next.sda_drive = 1'b1;
        n    = cmd.byte_count;
        last = 1'b0;

        // Idle commands: buffer push or transaction start
        if (phase_reg == PH_IDLE)
        begin
            if (op_t'(cmd.op) == OP_PUSH)
            begin
                if ({1'b0, fill_reg} < (FILL_W + 1)'(MAX_BYTES))
                begin
                    buf_we    = 1'b1;
                    fill_next = FILL_W'(fill_reg + FILL_W'(1));
                end
            end
            else if (op_t'(cmd.op) == OP_WRITE || op_t'(cmd.op) == OP_READ)
            begin
                if (32'(n) > MAX_BYTES)
                begin
                    n = 5'(MAX_BYTES);
                end
                rmode_next = (op_t'(cmd.op) == OP_READ);
                if (rmode_next && n == 5'd0)
                begin
                    n = 5'd1;
                end
                if (!rmode_next)
                begin
                    fill_next = '0;
                end
                tlen_next     = FILL_W'(n);
                taddr_next    = cmd.dev_addr;
                treg_next     = cmd.sub_addr;
                byte_idx_next = '0;
                bit_idx_next  = '0;
                tick_next     = '0;
                phase_next    = PH_ST_A;
            end
        end

        // Line levels for this tick
        last = is_last(byte_idx_next, tlen_next);
        case (phase_next)
            PH_ST_A:    begin res_next.scl = 1'b1; sda_lvl_next = 1'b1; end
            PH_ST_B:    begin res_next.scl = 1'b1; sda_lvl_next = 1'b0; end
            PH_WB_LO:
            begin
                res_next.scl = 1'b0;
                sda_lvl_next = shift_next[3'd7 - bit_idx_next[2:0]];
            end
            PH_WB_HI:
            begin
                res_next.scl = 1'b1;
                sda_lvl_next = shift_next[3'd7 - bit_idx_next[2:0]];
            end
            PH_WA_LO, PH_RB_LO:
            begin
                res_next.scl       = 1'b0;
                res_next.sda_drive = 1'b0;
            end
            PH_WA_HI, PH_RB_HI1, PH_RB_HI2:
            begin
                res_next.scl       = 1'b1;
                res_next.sda_drive = 1'b0;
            end
            PH_RA_LO:   res_next.scl = 1'b0;
            PH_RA_HI:   begin res_next.scl = 1'b1; sda_lvl_next = last; end
            PH_RA_LO2:  begin res_next.scl = 1'b0; sda_lvl_next = last; end
            PH_RA_END:  begin res_next.scl = 1'b0; sda_lvl_next = 1'b0; end
            PH_RS_PREP: begin res_next.scl = 1'b0; sda_lvl_next = 1'b1; end
            PH_SP_A:    begin res_next.scl = 1'b0; sda_lvl_next = 1'b0; end
            PH_SP_B:    begin res_next.scl = 1'b1; sda_lvl_next = 1'b0; end
            PH_SP_C:    begin res_next.scl = 1'b1; sda_lvl_next = 1'b1; end
            default:    begin res_next.scl = 1'b1; sda_lvl_next = 1'b1; end
        endcase
        res_next.sda_out = sda_lvl_next;

        // Phase timer and sequencing
        if (phase_next != PH_IDLE)
        begin
            res_next.busy_res = 1'b1;
            if (({1'b0, tick_next} + (TICK_W + 1)'(1)) < {1'b0, period})
            begin
                tick_next = TICK_W'(tick_next + TICK_W'(1));
            end
            else
            begin
                tick_next = '0;
                case (phase_next)
                    PH_ST_A:   phase_next = PH_ST_B;
                    PH_ST_B:
                    begin
                        shift_next   = tx_byte(byte_idx_next, rmode_next, taddr_next,
                                               treg_next, wb_entry);
                        bit_idx_next = '0;
                        phase_next   = PH_WB_LO;
                    end
                    PH_WB_LO:  phase_next = PH_WB_HI;
                    PH_WB_HI:
                    begin
                        bit_idx_next = 4'(bit_idx_next + 4'd1);
                        phase_next   = (bit_idx_next >= 4'd8) ? PH_WA_LO : PH_WB_LO;
                    end
                    PH_WA_LO:  phase_next = PH_WA_HI;
                    PH_WA_HI:
                    begin
                        ack_next     = cmd.sda_in;
                        bit_idx_next = '0;
                        if (!rmode_next)
                        begin
                            byte_idx_next = BYI_W'(byte_idx_next + BYI_W'(1));
                            if ({1'b0, byte_idx_next} <
                                ((BYI_W + 1)'(tlen_next) + (BYI_W + 1)'(2)))
                            begin
                                shift_next = tx_byte(byte_idx_next, rmode_next,
                                                     taddr_next, treg_next, wb_entry);
                                phase_next = PH_WB_LO;
                            end
                            else
                            begin
                                phase_next = PH_SP_A;
                            end
                        end
                        else if (byte_idx_next == BYI_W'(0))
                        begin
                            byte_idx_next = BYI_W'(1);
                            shift_next    = tx_byte(byte_idx_next, rmode_next,
                                                    taddr_next, treg_next, wb_entry);
                            phase_next    = PH_WB_LO;
                        end
                        else if (byte_idx_next == BYI_W'(1))
                        begin
                            byte_idx_next = BYI_W'(2);
                            phase_next    = PH_RS_PREP;
                        end
                        else
                        begin
                            byte_idx_next = BYI_W'(3);
                            shift_next    = '0;
                            phase_next    = PH_RB_LO;
                        end
                    end
                    PH_RB_LO:  phase_next = PH_RB_HI1;
                    PH_RB_HI1:
                    begin
                        shift_next   = {shift_next[6:0], cmd.sda_in};
                        bit_idx_next = 4'(bit_idx_next + 4'd1);
                        if (bit_idx_next >= 4'd8)
                        begin
                            res_next.rd_valid = 1'b1;
                            res_next.rd_byte  = shift_next;
                            res_next.rd_last  = is_last(byte_idx_next, tlen_next);
                        end
                        phase_next = PH_RB_HI2;
                    end
                    PH_RB_HI2:
                        phase_next = (bit_idx_next >= 4'd8) ? PH_RA_LO : PH_RB_LO;
                    PH_RA_LO:  phase_next = PH_RA_HI;
                    PH_RA_HI:  phase_next = PH_RA_LO2;
                    PH_RA_LO2: phase_next = PH_RA_END;
                    PH_RA_END:
                    begin
                        if (is_last(byte_idx_next, tlen_next))
                        begin
                            phase_next = PH_SP_A;
                        end
                        else
                        begin
                            byte_idx_next = BYI_W'(byte_idx_next + BYI_W'(1));
                            bit_idx_next  = '0;
                            shift_next    = '0;
                            phase_next    = PH_RB_LO;
                        end
                    end
                    PH_RS_PREP: phase_next = PH_ST_A;
                    PH_SP_A:    phase_next = PH_SP_B;
                    PH_SP_B:    phase_next = PH_SP_C;
                    default:
                    begin
                        res_next.done_res = 1'b1;
                        phase_next        = PH_IDLE;
                    end
                endcase
            end
        end
        res_next.nack = ack_next;
    end

    // Timing register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RST;
        end
        else if (cfg_we)
        begin
            phase_ticks_reg <= cfg_wdata;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            tick_reg     <= '0;
            bit_idx_reg  <= '0;
            byte_idx_reg <= '0;
            shift_reg    <= '0;
            fill_reg     <= '0;
            taddr_reg    <= '0;
            treg_reg     <= '0;
            tlen_reg     <= '0;
            ack_reg      <= 1'b0;
            sda_lvl_reg  <= 1'b1;
            rmode_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            bit_idx_reg  <= bit_idx_next;
            byte_idx_reg <= byte_idx_next;
            shift_reg    <= shift_next;
            fill_reg     <= fill_next;
            taddr_reg    <= taddr_next;
            treg_reg     <= treg_next;
            tlen_reg     <= tlen_next;
            ack_reg      <= ack_next;
            sda_lvl_reg  <= sda_lvl_next;
            rmode_reg    <= rmode_next;
        end
    end

    // Write buffer, contents undefined until pushed
    always_ff @(posedge clk)
    begin
        if (accept && buf_we)
        begin
            write_buf_reg[fill_reg[BUF_IDX_W-1:0]] <= cmd.wr_byte;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    // Result channel
    assign res.valid     = res_valid_reg;
    assign res.scl       = res_reg.scl;
    assign res.sda_out   = res_reg.sda_out;
    assign res.sda_drive = res_reg.sda_drive;
    assign res.rd_byte   = res_reg.rd_byte;
    assign res.rd_valid  = res_reg.rd_valid;
    assign res.rd_last   = res_reg.rd_last;
    assign res.busy_res  = res_reg.busy_res;
    assign res.done_res  = res_reg.done_res;
    assign res.nack      = res_reg.nack;

    // Checks
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.done_res |-> res_reg.busy_res)
        else $error("done without busy");

    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.rd_last |-> res_reg.rd_valid && res_reg.busy_res)
        else $error("rd_last without rd_valid");

    a_release_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_reg.sda_drive |-> res_reg.busy_res)
        else $error("SDA released while idle");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ({1'b0, fill_reg} <= (FILL_W + 1)'(MAX_BYTES)))
        else $error("write buffer overfilled");

endmodule

`default_nettype wire

// File: test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cra_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned IDLE_PCT    = 38;

    // One bus tick as offered on the command channel
    typedef struct packed {
        op_t        op;
        logic [6:0] dev_addr;
        logic [7:0] sub_addr;
        logic [4:0] byte_count;
        logic [7:0] wr_byte;
        logic       sda_in;
    } bus_cmd_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    i2cra_cmd_if cmd_ch ();
    i2cra_res_if res_ch ();

    i2c_master_register_access_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .res       (res_ch)
    );

    bus_cmd_t    bus_cmd_q[$];
    res_t        predicted_lines_q[$];
    bus_cmd_t    offered;
    res_t        want;
    int unsigned items_queued  = 0;
    int unsigned res_count     = 0;
    int unsigned mismatch_cnt  = 0;
    int unsigned stall_cycles  = 0;
    int unsigned hold_left     = 0;
    bit          hold_done     = 1'b0;

    // Shadow of the master: timing register and bus state
    logic [15:0] tick_period = PHASE_TICKS_RST;
    phase_t      bus_ph      = PH_IDLE;
    logic [15:0] tick_cnt    = '0;
    logic [3:0]  bit_idx     = '0;
    logic [4:0]  byte_idx    = '0;
    logic [7:0]  shift_reg   = '0;
    logic [7:0]  wbuf [MAX_BYTES];
    logic [4:0]  wfill       = '0;
    logic [6:0]  t_addr      = '0;
    logic [7:0]  t_reg       = '0;
    logic [4:0]  t_len       = '0;
    logic        ack_bit     = 1'b0;
    logic [1:0]  line_lv     = 2'b11;
    logic        rd_mode     = 1'b0;

    // Clock and initial levels on every input
    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.op        = OP_TICK;
        cmd_ch.dev_addr  = '0;
        cmd_ch.sub_addr  = '0;
        cmd_ch.byte_count = '0;
        cmd_ch.wr_byte   = '0;
        cmd_ch.sda_in    = 1'b0;
        res_ch.ready     = 1'b0;
        forever #2 clk = ~clk;
    end

    // No idling on either side while this window of results passes
    function automatic bit no_idle();
        return res_count >= 600 && res_count < 900;
    endfunction

    // ---------------------------------------------------------------
    // Bus shadow
    // ---------------------------------------------------------------

    // Last byte of a read: ACK turns into NACK
    function automatic logic last_rd_byte();
        return (int'(byte_idx) - 2) >= int'(t_len);
    endfunction

    // Next byte to shift out: address+W, register, address+R or data
    function automatic void load_tx_byte();
        int k;
        k = int'(byte_idx) - 2;
        if (byte_idx == 0)
            shift_reg = {t_addr, 1'b0};
        else if (byte_idx == 1)
            shift_reg = t_reg;
        else if (rd_mode)
            shift_reg = {t_addr, 1'b1};
        else
            shift_reg = (k < MAX_BYTES) ? wbuf[k[3:0]] : 8'h00;
        bit_idx = '0;
        bus_ph  = PH_WB_LO;
    endfunction

    // One tick of the master: line levels and status for this tick
    function automatic res_t step_i2c_master(bus_cmd_t c);
        res_t        r;
        int unsigned per;
        int unsigned n;
        r           = '0;
        r.scl       = 1'b1;
        r.sda_out   = line_lv[0];
        r.sda_drive = 1'b1;
        per         = (tick_period == 0) ? 1 : tick_period;

        // buffer pushes and transaction start, idle only
        if (bus_ph == PH_IDLE)
        begin
            if (c.op == OP_PUSH)
            begin
                if (wfill < MAX_BYTES)
                begin
                    wbuf[wfill[3:0]] = c.wr_byte;
                    wfill++;
                end
            end
            else if (c.op == OP_WRITE || c.op == OP_READ)
            begin
                n       = (c.byte_count > MAX_BYTES) ? MAX_BYTES : c.byte_count;
                rd_mode = (c.op == OP_READ);
                if (rd_mode && n == 0)
                    n = 1;
                if (!rd_mode)
                    wfill = '0;
                t_len    = n[4:0];
                t_addr   = c.dev_addr;
                t_reg    = c.sub_addr;
                byte_idx = '0;
                bit_idx  = '0;
                tick_cnt = '0;
                bus_ph   = PH_ST_A;
            end
        end

        // line levels of the current phase
        case (bus_ph)
            PH_ST_A:    begin r.scl = 1'b1; r.sda_out = 1'b1; end
            PH_ST_B:    begin r.scl = 1'b1; r.sda_out = 1'b0; end
            PH_WB_LO:   begin r.scl = 1'b0; r.sda_out = shift_reg[3'd7 - bit_idx[2:0]]; end
            PH_WB_HI:   begin r.scl = 1'b1; r.sda_out = shift_reg[3'd7 - bit_idx[2:0]]; end
            PH_WA_LO,
            PH_RB_LO:   begin r.scl = 1'b0; r.sda_drive = 1'b0; end
            PH_WA_HI,
            PH_RB_HI1,
            PH_RB_HI2:  begin r.scl = 1'b1; r.sda_drive = 1'b0; end
            PH_RA_LO:   r.scl = 1'b0;
            PH_RA_HI:   begin r.scl = 1'b1; r.sda_out = last_rd_byte(); end
            PH_RA_LO2:  begin r.scl = 1'b0; r.sda_out = last_rd_byte(); end
            PH_RA_END:  begin r.scl = 1'b0; r.sda_out = 1'b0; end
            PH_RS_PREP: begin r.scl = 1'b0; r.sda_out = 1'b1; end
            PH_SP_A:    begin r.scl = 1'b0; r.sda_out = 1'b0; end
            PH_SP_B:    begin r.scl = 1'b1; r.sda_out = 1'b0; end
            default:    begin r.scl = 1'b1; r.sda_out = 1'b1; end
        endcase
        line_lv = {r.scl, r.sda_out};

        // phase timing and transitions
        if (bus_ph != PH_IDLE)
        begin
            r.busy_res = 1'b1;
            if (int'(tick_cnt) + 1 < per)
                tick_cnt++;
            else
            begin
                tick_cnt = '0;
                case (bus_ph)
                    PH_ST_A:  bus_ph = PH_ST_B;
                    PH_ST_B:  load_tx_byte();
                    PH_WB_LO: bus_ph = PH_WB_HI;
                    PH_WB_HI:
                    begin
                        bit_idx++;
                        bus_ph = (bit_idx >= 8) ? PH_WA_LO : PH_WB_LO;
                    end
                    PH_WA_LO: bus_ph = PH_WA_HI;
                    PH_WA_HI:
                    begin
                        ack_bit = c.sda_in;
                        bit_idx = '0;
                        if (!rd_mode)
                        begin
                            byte_idx++;
                            if (int'(byte_idx) < 2 + int'(t_len))
                                load_tx_byte();
                            else
                                bus_ph = PH_SP_A;
                        end
                        else if (byte_idx == 0)
                        begin
                            byte_idx = 5'd1;
                            load_tx_byte();
                        end
                        else if (byte_idx == 1)
                        begin
                            byte_idx = 5'd2;
                            bus_ph   = PH_RS_PREP;
                        end
                        else
                        begin
                            byte_idx  = 5'd3;
                            shift_reg = '0;
                            bus_ph    = PH_RB_LO;
                        end
                    end
                    PH_RB_LO: bus_ph = PH_RB_HI1;
                    PH_RB_HI1:
                    begin
                        shift_reg = {shift_reg[6:0], c.sda_in};
                        bit_idx++;
                        if (bit_idx >= 8)
                        begin
                            r.rd_valid = 1'b1;
                            r.rd_byte  = shift_reg;
                            r.rd_last  = last_rd_byte();
                        end
                        bus_ph = PH_RB_HI2;
                    end
                    PH_RB_HI2: bus_ph = (bit_idx >= 8) ? PH_RA_LO : PH_RB_LO;
                    PH_RA_LO:  bus_ph = PH_RA_HI;
                    PH_RA_HI:  bus_ph = PH_RA_LO2;
                    PH_RA_LO2: bus_ph = PH_RA_END;
                    PH_RA_END:
                    begin
                        if (last_rd_byte())
                            bus_ph = PH_SP_A;
                        else
                        begin
                            byte_idx++;
                            bit_idx   = '0;
                            shift_reg = '0;
                            bus_ph    = PH_RB_LO;
                        end
                    end
                    PH_RS_PREP: bus_ph = PH_ST_A;
                    PH_SP_A:    bus_ph = PH_SP_B;
                    PH_SP_B:    bus_ph = PH_SP_C;
                    default:
                    begin
                        r.done_res = 1'b1;
                        bus_ph     = PH_IDLE;
                    end
                endcase
            end
        end
        r.nack = ack_bit;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    task automatic add_tick(op_t op, logic [6:0] a, logic [7:0] rg, logic [4:0] n,
                            logic [7:0] b, logic s);
        bus_cmd_t c;
        c.op         = op;
        c.dev_addr   = a;
        c.sub_addr   = rg;
        c.byte_count = n;
        c.wr_byte    = b;
        c.sda_in     = s;
        bus_cmd_q.push_back(c);
        items_queued++;
    endtask

    // Ticks with random content; only used while a transaction is running
    task automatic add_noise(int unsigned k);
        repeat (k)
            add_tick(op_t'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                     8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic add_plain(int unsigned k);
        repeat (k)
            add_tick(OP_TICK, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                     5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
    endtask

    task automatic add_push(logic [7:0] b);
        add_tick(OP_PUSH, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                 5'($urandom_range(0, 31)), b, 1'($urandom_range(0, 1)));
    endtask

    // Ticks from the start tick to the STOP tick inclusive
    function automatic int unsigned xfer_ticks(op_t op, logic [4:0] cnt);
        int unsigned n;
        int unsigned per;
        n   = (cnt > MAX_BYTES) ? MAX_BYTES : cnt;
        per = (tick_period == 0) ? 1 : tick_period;
        if (op == OP_READ)
            return (62 + 28 * ((n == 0) ? 1 : n)) * per;
        return (41 + 18 * n) * per;
    endfunction

    // Start tick followed by random ticks for the whole transaction
    task automatic add_xfer(op_t op, logic [6:0] a, logic [7:0] rg, logic [4:0] n);
        add_tick(op, a, rg, n, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        add_noise(xfer_ticks(op, n) - 1);
    endtask

    task automatic wait_drained();
        while (!(bus_cmd_q.size() == 0 && !cmd_ch.valid && predicted_lines_q.size() == 0))
            @(posedge clk);
    endtask

    // Timing register write once everything has come back
    task automatic set_phase_ticks(logic [15:0] v);
        wait_drained();
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we      <= 1'b0;
        tick_period  = v;
    endtask

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned  base;
        int unsigned  per;
        logic [4:0]   n;
        logic [15:0]  periods [4];
        periods = '{16'd0, 16'd2, 16'd1, 16'd3};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset timing: empty write
        add_xfer(OP_WRITE, 7'h00, 8'hFF, 5'd0);

        // fill the buffer past full, oversize write and read
        set_phase_ticks(16'd1);
        add_push(8'h00);
        add_push(8'hFF);
        repeat (15)
            add_push(8'($urandom_range(0, 255)));
        add_xfer(OP_WRITE, 7'h55, 8'hAA, 5'd31);
        add_push(8'h5A);
        add_xfer(OP_READ, 7'h7F, 8'hFF, 5'd31);

        // random traffic over several timing settings
        foreach (periods[i])
        begin
            set_phase_ticks(periods[i]);
            per  = (periods[i] == 0) ? 1 : periods[i];
            base = items_queued;
            while (items_queued - base < 40)
            begin
                add_plain($urandom_range(0, 3));
                repeat ($urandom_range(0, 4))
                    add_push(8'($urandom_range(0, 255)));
                if (per > 1)
                    n = 5'($urandom_range(0, 1));
                else
                    n = 5'($urandom_range(0, 3));
                add_xfer($urandom_range(0, 1) ? OP_READ : OP_WRITE,
                         7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), n);
            end
        end

        // slowest timing: start a write, then speed up part way into START
        set_phase_ticks(16'hFFFF);
        add_push(8'($urandom_range(0, 255)));
        add_tick(OP_WRITE, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), 5'd0,
                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        add_noise(20);
        set_phase_ticks(16'd1);
        add_noise(41);
        add_plain(8);

        // wait for the tail, then wait on for stray results
        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // ---------------------------------------------------------------
    // Command driver; predicts on every accepted transaction
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            cmd_ch.valid <= 1'b0;
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
                predicted_lines_q.push_back(step_i2c_master(offered));
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (bus_cmd_q.size() != 0 &&
                    (no_idle() || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    offered              = bus_cmd_q.pop_front();
                    cmd_ch.valid        <= 1'b1;
                    cmd_ch.op           <= offered.op;
                    cmd_ch.dev_addr     <= offered.dev_addr;
                    cmd_ch.sub_addr     <= offered.sub_addr;
                    cmd_ch.byte_count   <= offered.byte_count;
                    cmd_ch.wr_byte      <= offered.wr_byte;
                    cmd_ch.sda_in       <= offered.sda_in;
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result monitor and checker
    // ---------------------------------------------------------------
    task automatic report_mismatch(string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 100)
            $display("[%0t] result %0d: %s", $realtime, res_count, msg);
    endtask

    task automatic compare_field(string name, int unsigned got, int unsigned exp_val);
        if (got != exp_val)
            report_mismatch($sformatf("%s got 0x%0h, predicted 0x%0h", name, got, exp_val));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                res_count++;
                if (predicted_lines_q.size() == 0)
                    report_mismatch("transaction with no prediction waiting");
                else
                begin
                    want = predicted_lines_q.pop_front();
                    compare_field("scl", res_ch.scl, want.scl);
                    compare_field("sda_out", res_ch.sda_out, want.sda_out);
                    compare_field("sda_drive", res_ch.sda_drive, want.sda_drive);
                    compare_field("rd_byte", res_ch.rd_byte, want.rd_byte);
                    compare_field("rd_valid", res_ch.rd_valid, want.rd_valid);
                    compare_field("rd_last", res_ch.rd_last, want.rd_last);
                    compare_field("busy_res", res_ch.busy_res, want.busy_res);
                    compare_field("done_res", res_ch.done_res, want.done_res);
                    compare_field("nack", res_ch.nack, want.nack);
                end
            end

            // one long hold-off while commands keep coming, to back up the input
            if (!hold_done && res_count >= 300 && bus_cmd_q.size() > 100)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= no_idle() || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: cycles without a transaction on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                stall_cycles <= 0;
            else if (stall_cycles + 1 >= STALL_LIMIT)
            begin
                $display("[%0t] no transaction for %0d cycles", $realtime, STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
